@@ sv/tmc_pkg.sv @@
// ============================================================================
// tmc_pkg - shared types and constants for the tour mutation and cost block
// Field layout, opcodes, status codes and controller/datapath interface.
// ============================================================================
package tmc_pkg;

    localparam int MAX_CITIES = 1024;
    localparam int COORD_BITS = 16;

    localparam int IDX_W   = $clog2(MAX_CITIES);
    localparam int SIZE_W  = IDX_W + 1;
    localparam int CITY_W  = IDX_W;
    localparam int COORD_W = 2 * COORD_BITS;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int COST_W  = 44;
    localparam int DRAW_W  = 7;
    localparam int RATE_W  = 7;
    localparam int STAT_W  = 2;
    localparam int OP_W    = 2;

    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_CITIES);
    localparam logic [COST_W-1:0] COST_MAX = '1;

    // input tdata layout
    localparam int OP_LSB    = 0;
    localparam int I1_LSB    = OP_LSB + OP_W;
    localparam int I2_LSB    = I1_LSB + IDX_W;
    localparam int CITY_LSB  = I2_LSB + IDX_W;
    localparam int X_LSB     = CITY_LSB + CITY_W;
    localparam int Y_LSB     = X_LSB + 16;
    localparam int DRAW_LSB  = Y_LSB + 16;
    localparam int S_TDATA_W = 72;

    // output tdata layout
    localparam int M_TDATA_W = 48;
    localparam int M_PAD_W   = M_TDATA_W - COST_W - STAT_W;

    // config port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 11;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_COORD = 2'd0,
        OP_LOAD_SLOT  = 2'd1,
        OP_MUTATE     = 2'd2,
        OP_RECOMPUTE  = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_REJECT    = 2'd1,
        ST_BAD_INDEX = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOUR_SIZE = 2'd0,
        CFG_RATE      = 2'd1,
        CFG_POLICY    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic    latch;
        logic    wr_coord;
        logic    wr_slot;
        logic    perm_start;
        logic    walk_start;
        logic    load_out;
        status_t out_status;
    } dp_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    load_bad;
        logic    draw_reject;
        logic    mut_idx_bad;
        logic    perm_busy;
        logic    walk_busy;
    } dp_stat_t;

endpackage

@@ sv/tour_mutation_and_cost.sv @@
// ============================================================================
// tour_mutation_and_cost - tour mutation and closed-tour cost unit
// Holds a city coordinate table and a tour; loads, mutates and costs it.
// ============================================================================
// Usage:
//   s_ channel: one command item per transfer (load coordinate, load tour
//     slot, mutate, recompute cost). s_tready is high only while the unit is
//     idle; one item is worked on at a time.
//   m_ channel: exactly one result item per command: current cost and status.
//     The result sits in an output register, so the next command is taken
//     while it waits; a command that finishes before the result is taken
//     holds until m_tready frees the register.
//   cfg_ port: plain register writes (tour size, rate percent, policy). The
//     user must write them only while the unit is idle; it is not enforced.
// Sequence, from the accepting edge to m_tvalid, n = tour size in use; s_tready
//   comes back with m_tvalid:
//   loads: decode and write the RAM, then the result register.
//   recompute: the cost walk over positions 0..n streams one tour slot a
//     cycle through tour RAM, coord RAM, subtract, square, accumulate.
//   mutate: the swap, or a reverse that swaps pairs from the span ends inward,
//     then the cost walk.
//   rejected or bad-index mutate: decode, then straight to the result.
// Reset: config and cost clear to zero; RAM contents are undefined until
//   written, and no clearing pass runs.
// ============================================================================
module tour_mutation_and_cost
    import tmc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input item
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata: opcode[1:0], first_index[11:2], second_index[21:12], city[31:22],
    //        coord_x[47:32], coord_y[63:48], draw[70:64], zero pad[71]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // result item
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata: total_cost[43:0], status[45:44], zero pad[47:46]
    output logic [M_TDATA_W-1:0] m_tdata,
    // config write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tmc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    tmc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata)
    );

endmodule

@@ sv/tmc_ram.sv @@
// ============================================================================
// tmc_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ============================================================================
module tmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/tmc_ctrl.sv @@
// ============================================================================
// tmc_ctrl - item sequencer
// Accepts one item, decodes it, writes a RAM or runs permutation and/or cost walk, emits result.
// ============================================================================
module tmc_ctrl
    import tmc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PERM,
        S_WALK,
        S_FINISH
    } state_t;

    state_t  state_reg, state_next;
    status_t st_reg, st_next;
    logic    m_tvalid_reg;

    always_comb begin
        cmd            = '0;
        cmd.out_status = st_reg;
        state_next     = state_reg;
        st_next        = st_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                st_next = ST_OK;
                unique case (stat.op)
                    OP_LOAD_COORD: begin
                        if (stat.load_bad) st_next = ST_BAD_INDEX;
                        else               cmd.wr_coord = 1'b1;
                        state_next = S_FINISH;
                    end
                    OP_LOAD_SLOT: begin
                        if (stat.load_bad) st_next = ST_BAD_INDEX;
                        else               cmd.wr_slot = 1'b1;
                        state_next = S_FINISH;
                    end
                    OP_MUTATE: begin
                        priority if (stat.draw_reject) begin
                            st_next    = ST_REJECT;
                            state_next = S_FINISH;
                        end else if (stat.mut_idx_bad) begin
                            st_next    = ST_BAD_INDEX;
                            state_next = S_FINISH;
                        end else begin
                            cmd.perm_start = 1'b1;
                            state_next     = S_PERM;
                        end
                    end
                    OP_RECOMPUTE: begin
                        cmd.walk_start = 1'b1;
                        state_next     = S_WALK;
                    end
                endcase
            end
            S_PERM: begin
                if (!stat.perm_busy) begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_WALK;
                end
            end
            S_WALK: begin
                if (!stat.walk_busy) state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            st_reg       <= ST_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
            if (cmd.load_out)  m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

@@ sv/tmc_dp.sv @@
// ============================================================================
// tmc_dp - datapath
// Config registers, item latch, tour/coord RAMs, pair-swap engine,
// pipelined cost walk and the output register.
// ============================================================================
module tmc_dp
    import tmc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat,
    output logic [M_TDATA_W-1:0]   m_tdata
);

    // ---------------- config ----------------
    logic [SIZE_W-1:0] tour_size_reg;
    logic [RATE_W-1:0] rate_reg;
    logic              policy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tour_size_reg <= '0;
            rate_reg      <= '0;
            policy_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TOUR_SIZE: tour_size_reg <= cfg_wdata[SIZE_W-1:0];
                CFG_RATE:      rate_reg      <= cfg_wdata[RATE_W-1:0];
                CFG_POLICY:    policy_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic [SIZE_W-1:0] n_use;
    assign n_use = (tour_size_reg > MAX_SIZE) ? MAX_SIZE : tour_size_reg;

    // ---------------- item latch ----------------
    logic [OP_W-1:0]       op_reg;
    logic [IDX_W-1:0]      i1_reg, i2_reg;
    logic [CITY_W-1:0]     city_reg;
    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic [DRAW_W-1:0]     draw_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg   <= s_tdata[OP_LSB +: OP_W];
            i1_reg   <= s_tdata[I1_LSB +: IDX_W];
            i2_reg   <= s_tdata[I2_LSB +: IDX_W];
            city_reg <= s_tdata[CITY_LSB +: CITY_W];
            x_reg    <= s_tdata[X_LSB +: COORD_BITS];
            y_reg    <= s_tdata[Y_LSB +: COORD_BITS];
            draw_reg <= s_tdata[DRAW_LSB +: DRAW_W];
        end
    end

    logic [SIZE_W-1:0] i1_w, i2_w, city_w;
    assign i1_w   = {1'b0, i1_reg};
    assign i2_w   = {1'b0, i2_reg};
    assign city_w = {1'b0, city_reg};

    // ---------------- RAMs ----------------
    logic              tour_we;
    logic [IDX_W-1:0]  tour_waddr, tour_raddr;
    logic [CITY_W-1:0] tour_wdata, tour_rdata;
    logic [COORD_W-1:0] coord_rdata;

    tmc_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_tour_ram (
        .aclk  (aclk),
        .we    (tour_we),
        .waddr (tour_waddr),
        .wdata (tour_wdata),
        .raddr (tour_raddr),
        .rdata (tour_rdata)
    );

    // coord word: y in the upper half, x in the lower
    tmc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_CITIES)) u_coord_ram (
        .aclk  (aclk),
        .we    (cmd.wr_coord),
        .waddr (i1_reg),
        .wdata ({y_reg, x_reg}),
        .raddr (tour_rdata),
        .rdata (coord_rdata)
    );

    // ---------------- pair-swap engine ----------------
    // Span [pa, pb): pair is (pa, pb-1). Reads A then B, then writes A<-B and B<-A,
    // overlapped with the next pair's reads.
    logic              perm_run_reg, phase_reg, swap_mode_reg, swap_left_reg;
    logic [SIZE_W-1:0] pa_reg, pb_reg, pb_m1;
    logic              rd_v_reg, rd_isb_reg, wpend_reg;
    logic [IDX_W-1:0]  wa_reg, wb_reg, addr_a, addr_b, perm_raddr;
    logic [CITY_W-1:0] da_reg;
    logic              perm_more, perm_rd_en;

    assign pb_m1      = pb_reg - SIZE_W'(1);
    assign addr_a     = pa_reg[IDX_W-1:0];
    assign addr_b     = pb_m1[IDX_W-1:0];
    assign perm_more  = swap_mode_reg ? swap_left_reg : ((pa_reg + SIZE_W'(1)) < pb_reg);
    assign perm_rd_en = perm_run_reg && (phase_reg || perm_more);
    assign perm_raddr = phase_reg ? addr_b : addr_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            perm_run_reg <= 1'b0;
            phase_reg    <= 1'b0;
            rd_v_reg     <= 1'b0;
            wpend_reg    <= 1'b0;
        end else begin
            rd_v_reg <= perm_rd_en;
            if (cmd.perm_start) begin
                perm_run_reg  <= 1'b1;
                phase_reg     <= 1'b0;
                swap_mode_reg <= !policy_reg;
                swap_left_reg <= 1'b1;
                if (!policy_reg) begin
                    pa_reg <= i1_w;
                    pb_reg <= i2_w + SIZE_W'(1);
                end else begin
                    pa_reg <= (i1_w < i2_w) ? i1_w : i2_w;
                    pb_reg <= (i1_w < i2_w) ? i2_w : i1_w;
                end
            end else if (perm_run_reg) begin
                if (!phase_reg) begin
                    if (perm_more) begin
                        wa_reg     <= addr_a;
                        rd_isb_reg <= 1'b0;
                        phase_reg  <= 1'b1;
                    end else begin
                        perm_run_reg <= 1'b0;
                    end
                end else begin
                    wb_reg        <= addr_b;
                    rd_isb_reg    <= 1'b1;
                    phase_reg     <= 1'b0;
                    pa_reg        <= pa_reg + SIZE_W'(1);
                    pb_reg        <= pb_m1;
                    swap_left_reg <= 1'b0;
                end
            end
            if (rd_v_reg && !rd_isb_reg) da_reg <= tour_rdata;
            if (rd_v_reg && rd_isb_reg) wpend_reg <= 1'b1;
            else                        wpend_reg <= 1'b0;
        end
    end

    always_comb begin
        tour_we    = 1'b0;
        tour_waddr = i1_reg;
        tour_wdata = city_reg;
        priority if (cmd.wr_slot) begin
            tour_we = 1'b1;
        end else if (rd_v_reg && rd_isb_reg) begin
            tour_we    = 1'b1;
            tour_waddr = wa_reg;
            tour_wdata = tour_rdata;
        end else if (wpend_reg) begin
            tour_we    = 1'b1;
            tour_waddr = wb_reg;
            tour_wdata = da_reg;
        end
    end

    // ---------------- cost walk ----------------
    // positions 0..n, position n reads slot 0 again to close the tour
    logic                     walk_run_reg;
    logic [SIZE_W-1:0]        cnt_reg;
    logic [IDX_W-1:0]         walk_raddr;
    logic                     t1_v_reg, t1_first_reg, c2_v_reg, c2_first_reg;
    logic                     e3_v_reg, s4_v_reg;
    logic signed [COORD_BITS-1:0] cx, cy, prev_x_reg, prev_y_reg;
    logic signed [DIFF_W-1:0] dx_next, dy_next, dx_reg, dy_reg;
    logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;
    logic [COST_W:0]          sum_w;
    logic [COST_W-1:0]        cost_reg;

    assign walk_raddr = (cnt_reg == n_use) ? '0 : cnt_reg[IDX_W-1:0];
    assign tour_raddr = perm_run_reg ? perm_raddr : walk_raddr;

    assign cx       = coord_rdata[COORD_BITS-1:0];
    assign cy       = coord_rdata[COORD_W-1:COORD_BITS];
    assign dx_next  = DIFF_W'(cx) - DIFF_W'(prev_x_reg);
    assign dy_next  = DIFF_W'(cy) - DIFF_W'(prev_y_reg);
    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;
    assign sum_w    = {1'b0, cost_reg} + (COST_W+1)'(sqx_reg) + (COST_W+1)'(sqy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_run_reg <= 1'b0;
            t1_v_reg     <= 1'b0;
            c2_v_reg     <= 1'b0;
            e3_v_reg     <= 1'b0;
            s4_v_reg     <= 1'b0;
            cost_reg     <= '0;
        end else begin
            t1_v_reg     <= walk_run_reg;
            t1_first_reg <= (cnt_reg == '0);
            c2_v_reg     <= t1_v_reg;
            c2_first_reg <= t1_first_reg;
            e3_v_reg     <= c2_v_reg && !c2_first_reg;
            s4_v_reg     <= e3_v_reg;
            if (cmd.walk_start) begin
                cost_reg     <= '0;
                cnt_reg      <= '0;
                walk_run_reg <= (n_use > SIZE_W'(1));
            end else if (walk_run_reg) begin
                cnt_reg <= cnt_reg + SIZE_W'(1);
                if (cnt_reg == n_use) walk_run_reg <= 1'b0;
            end
            if (c2_v_reg) begin
                prev_x_reg <= cx;
                prev_y_reg <= cy;
                dx_reg     <= dx_next;
                dy_reg     <= dy_next;
            end
            if (e3_v_reg) begin
                sqx_reg <= sqx_full[SQ_W-1:0];
                sqy_reg <= sqy_full[SQ_W-1:0];
            end
            if (s4_v_reg) begin
                cost_reg <= sum_w[COST_W] ? COST_MAX : sum_w[COST_W-1:0];
            end
        end
    end

    // ---------------- status to controller ----------------
    always_comb begin
        stat.op          = opcode_t'(op_reg);
        stat.draw_reject = (draw_reg >= rate_reg);
        stat.mut_idx_bad = (i1_w >= n_use) || (i2_w >= n_use);
        if (opcode_t'(op_reg) == OP_LOAD_COORD) stat.load_bad = (i1_w >= MAX_SIZE);
        else stat.load_bad = (i1_w >= MAX_SIZE) || (city_w >= MAX_SIZE);
        stat.perm_busy   = perm_run_reg || rd_v_reg || wpend_reg;
        stat.walk_busy   = walk_run_reg || t1_v_reg || c2_v_reg || e3_v_reg || s4_v_reg;
    end

    // ---------------- output register ----------------
    logic [COST_W-1:0] out_cost_reg;
    status_t           out_status_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_cost_reg   <= cost_reg;
            out_status_reg <= cmd.out_status;
        end
    end

    assign m_tdata = {{M_PAD_W{1'b0}}, out_status_reg, out_cost_reg};

endmodule
